FILE: rtl/scpf_pkg.sv
package scpf_pkg;

    // Frame constants
    localparam logic [7:0] SYNC_HI = 8'hEF;
    localparam logic [7:0] SYNC_LO = 8'h01;
    localparam logic [7:0] LEN_HI  = 8'h00;
    localparam logic [31:0] ADDR_RESET = 32'hFFFF_FFFF;

    // One content byte word on the command channel
    typedef struct packed {
        logic [7:0] packet_id;
        logic [7:0] packet_length;
        logic [7:0] data_byte;
        logic       first_of_packet;
        logic       last_of_packet;
    } cmd_word_t;

    // One framed byte word on the transmit channel
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       packet_end;
        logic       run_last;
    } tx_word_t;

    // Accepted word as held by the emitter, checksum already folded in
    typedef struct packed {
        logic [7:0]  packet_id;
        logic [7:0]  packet_length;
        logic [7:0]  data_byte;
        logic [15:0] sum;
        logic        first;
        logic        last;
    } item_t;

    // Position within the framed packet
    typedef enum logic [3:0] {
        PH_SYNC_HI,
        PH_SYNC_LO,
        PH_ADDR_3,
        PH_ADDR_2,
        PH_ADDR_1,
        PH_ADDR_0,
        PH_PID,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_DATA,
        PH_SUM_HI,
        PH_SUM_LO
    } phase_t;

endpackage

FILE: rtl/scpf_emit.sv
module scpf_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  scpf_pkg::item_t  item,
    input  logic [31:0]      address,
    output logic             item_free,
    output logic             tx_valid,
    input  logic             tx_stall,
    output scpf_pkg::tx_word_t tx_word
);
    import scpf_pkg::*;

    item_t    item_reg;
    logic     item_valid_reg, item_valid_next;
    phase_t   phase_reg, phase_next;
    phase_t   end_phase;
    logic     out_valid_reg, out_valid_next;
    tx_word_t out_reg, out_next;
    logic     out_free;
    logic     emit;
    logic     done;
    logic [7:0] sel_byte;

    // Handshake toward the output register
    assign out_free  = !out_valid_reg || !tx_stall;
    assign emit      = item_valid_reg && out_free;
    assign end_phase = item_reg.last ? PH_SUM_LO : PH_DATA;
    assign done      = emit && (phase_reg == end_phase);
    assign item_free = !item_valid_reg || done;

    // Byte for the current position
    always_comb
    begin
        unique case (phase_reg)
            PH_SYNC_HI: sel_byte = SYNC_HI;
            PH_SYNC_LO: sel_byte = SYNC_LO;
            PH_ADDR_3:  sel_byte = address[31:24];
            PH_ADDR_2:  sel_byte = address[23:16];
            PH_ADDR_1:  sel_byte = address[15:8];
            PH_ADDR_0:  sel_byte = address[7:0];
            PH_PID:     sel_byte = item_reg.packet_id;
            PH_LEN_HI:  sel_byte = LEN_HI;
            PH_LEN_LO:  sel_byte = item_reg.packet_length;
            PH_DATA:    sel_byte = item_reg.data_byte;
            PH_SUM_HI:  sel_byte = item_reg.sum[15:8];
            PH_SUM_LO:  sel_byte = item_reg.sum[7:0];
            default:    sel_byte = '0;
        endcase
    end

    // Next position and item occupancy
    always_comb
    begin
        item_valid_next = item_valid_reg;
        phase_next      = phase_reg;
        if (load)
        begin
            item_valid_next = 1'b1;
            phase_next      = item.first ? PH_SYNC_HI : PH_DATA;
        end
        else if (done)
        begin
            item_valid_next = 1'b0;
        end
        else if (emit)
        begin
            phase_next = phase_t'(phase_reg + 4'd1);
        end
    end

    // Output register contents
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next      = 1'b1;
            out_next.tx_byte    = sel_byte;
            out_next.packet_end = (phase_reg == PH_SUM_LO);
            out_next.run_last   = (phase_reg == end_phase);
        end
        else if (!tx_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            phase_reg      <= PH_DATA;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            phase_reg      <= phase_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
        out_reg <= out_next;
    end

    assign tx_valid = out_valid_reg;
    assign tx_word  = out_reg;

`ifndef ASSERT_OFF
    // a new word only lands in a free or draining slot
    assert property (@(posedge clk) disable iff (!rst_n) load |-> item_free)
        else $error("word loaded over a busy slot");

    // checksum positions only occur for a word that closes a packet
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && (phase_reg == PH_SUM_HI || phase_reg == PH_SUM_LO))
            |-> item_reg.last)
        else $error("checksum emitted for a non-final word");

    // packet end is always the final byte of its word
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.packet_end) |-> out_reg.run_last)
        else $error("packet end without run end");

    // a word that ends in a checksum finishes on the low checksum byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && item_reg.last) |=> (out_reg.packet_end && out_valid_reg))
        else $error("last word finished without checksum low byte");
`endif

endmodule

FILE: rtl/sensor_command_packet_framer.sv
// Channel | Direction | Handshake          | Word
// cmd     | in        | cmd_valid/cmd_stall | cmd_word_t: content byte with id, length, marks
// tx      | out       | tx_valid/tx_stall   | tx_word_t: framed byte with end marks
// cfg     | in        | cfg_we              | cfg_data: 32-bit device address
//
// One framed byte leaves per cycle through the output register while tx is not stalled;
// a word gives one byte, plus 9 when it opens a packet and 2 when it closes one.
// A plain content word is taken every cycle while tx is not stalled.
// Reset clears the address to all ones and the checksum to zero.
// tx_stall holds the output register; cmd_stall rises while a word is still emitting.
module sensor_command_packet_framer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  scpf_pkg::cmd_word_t cmd_word,
    output logic                tx_valid,
    input  logic                tx_stall,
    output scpf_pkg::tx_word_t  tx_word,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_data
);
    import scpf_pkg::*;

    logic [31:0] addr_reg;
    logic [15:0] sum_reg, sum_next;
    logic [15:0] sum_base;
    logic [15:0] item_sum;
    logic        item_free;
    logic        load;
    item_t       item;

    assign cmd_stall = !item_free;
    assign load      = cmd_valid && item_free;

    // Checksum including this word
    assign sum_base = cmd_word.first_of_packet
                    ? ({8'd0, cmd_word.packet_id} + {8'd0, cmd_word.packet_length})
                    : sum_reg;
    assign item_sum = sum_base + {8'd0, cmd_word.data_byte};

    always_comb
    begin
        sum_next = sum_reg;
        if (load)
        begin
            sum_next = cmd_word.last_of_packet ? 16'd0 : item_sum;
        end
    end

    // Word handed to the emitter
    always_comb
    begin
        item.packet_id     = cmd_word.packet_id;
        item.packet_length = cmd_word.packet_length;
        item.data_byte     = cmd_word.data_byte;
        item.sum           = item_sum;
        item.first         = cmd_word.first_of_packet;
        item.last          = cmd_word.last_of_packet;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= ADDR_RESET;
            sum_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                addr_reg <= cfg_data;
            end
            sum_reg <= sum_next;
        end
    end

    scpf_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .item      (item),
        .address   (addr_reg),
        .item_free (item_free),
        .tx_valid  (tx_valid),
        .tx_stall  (tx_stall),
        .tx_word   (tx_word)
    );

endmodule

FILE: verif/tb.sv
module tb;

    import scpf_pkg::*;

    // Directed row: one command word plus, where it is obvious, the framed bytes typed in
    typedef struct packed {
        cmd_word_t   w;
        logic [3:0]  typed_n;
        logic [95:0] typed;
    } stim_row_t;

    localparam int NUM_DIRECTED = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    cmd_word_t   cmd_word = '0;
    logic        tx_valid;
    logic        tx_stall = 1'b0;
    tx_word_t    tx_word;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_data = '0;

    // Framer state as the checker sees it
    logic [31:0] dev_addr = ADDR_RESET;
    logic [15:0] frame_sum = '0;

    tx_word_t    framed [0:11];
    int          framed_n;
    tx_word_t    tx_expected [$];
    stim_row_t   offered [$];
    stim_row_t   directed_rows [0:NUM_DIRECTED-1];
    int          mismatches = 0;
    bit          quiet = 1'b0;

    sensor_command_packet_framer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .tx_valid  (tx_valid),
        .tx_stall  (tx_stall),
        .tx_word   (tx_word),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #1000000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic note_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    function automatic void put_framed(input logic [7:0] b, input logic is_end);
        framed[framed_n].tx_byte    = b;
        framed[framed_n].packet_end = is_end;
        framed[framed_n].run_last   = 1'b0;
        framed_n++;
    endfunction

    // Bytes one command word produces; updates the running checksum
    function automatic void frame_word(input cmd_word_t w);
        logic [15:0] sum;
        sum = frame_sum;
        framed_n = 0;
        if (w.first_of_packet)
        begin
            put_framed(SYNC_HI, 1'b0);
            put_framed(SYNC_LO, 1'b0);
            for (int i = 3; i >= 0; i--)
                put_framed(dev_addr[i*8 +: 8], 1'b0);
            put_framed(w.packet_id, 1'b0);
            put_framed(LEN_HI, 1'b0);
            put_framed(w.packet_length, 1'b0);
            sum = 16'(w.packet_id) + 16'(w.packet_length);
        end
        put_framed(w.data_byte, 1'b0);
        sum = sum + 16'(w.data_byte);
        if (w.last_of_packet)
        begin
            put_framed(sum[15:8], 1'b0);
            put_framed(sum[7:0], 1'b1);
            frame_sum = '0;
        end
        else
        begin
            frame_sum = sum;
        end
        framed[framed_n-1].run_last = 1'b1;
    endfunction

    function automatic stim_row_t plan_row(input logic [7:0] pid, input logic [7:0] len,
                                           input logic [7:0] dat, input logic first,
                                           input logic last, input logic [3:0] n,
                                           input logic [95:0] bytes);
        stim_row_t r;
        r.w.packet_id       = pid;
        r.w.packet_length   = len;
        r.w.data_byte       = dat;
        r.w.first_of_packet = first;
        r.w.last_of_packet  = last;
        r.typed_n           = n;
        r.typed             = bytes;
        return r;
    endfunction

    // Accepted command words queue their bytes; accepted tx words are checked
    always @(posedge clk)
    begin
        stim_row_t row;
        tx_word_t  want;
        if (rst_n && cmd_valid && !cmd_stall)
        begin
            row = offered.pop_front();
            frame_word(cmd_word);
            if (row.typed_n != 0)
            begin
                framed_n = int'(row.typed_n);
                for (int i = 0; i < framed_n; i++)
                begin
                    framed[i].tx_byte    = row.typed[95 - 8*i -: 8];
                    framed[i].packet_end = (i == framed_n - 1) && row.w.last_of_packet;
                    framed[i].run_last   = (i == framed_n - 1);
                end
            end
            for (int i = 0; i < framed_n; i++)
                tx_expected.push_back(framed[i]);
        end
        if (rst_n && tx_valid && !tx_stall)
        begin
            if (tx_expected.size() == 0)
                note_mismatch($sformatf("tx word %h with nothing expected", tx_word));
            else
            begin
                want = tx_expected.pop_front();
                if (tx_word.tx_byte !== want.tx_byte)
                    note_mismatch($sformatf("tx_byte %h, expected %h",
                                            tx_word.tx_byte, want.tx_byte));
                if (tx_word.packet_end !== want.packet_end)
                    note_mismatch($sformatf("packet_end %b, expected %b",
                                            tx_word.packet_end, want.packet_end));
                if (tx_word.run_last !== want.run_last)
                    note_mismatch($sformatf("run_last %b, expected %b",
                                            tx_word.run_last, want.run_last));
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
        tx_stall <= !quiet && ($urandom_range(0, 99) < 21);

    task automatic send_word(input stim_row_t row);
        while (!quiet && $urandom_range(0, 99) < 21)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        offered.push_back(row);
        cmd_valid <= 1'b1;
        cmd_word  <= row.w;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    task automatic send_random(input logic first, input logic last);
        send_word(plan_row(8'($urandom_range(0, 255)), 8'($urandom_range(3, 255)),
                           8'($urandom_range(0, 255)), first, last, 4'd0, '0));
    endtask

    // Address change only once the framer has drained
    task automatic write_address(input logic [31:0] addr);
        cmd_valid <= 1'b0;
        // let the checker queue the bytes of the last accepted word first
        @(posedge clk);
        while (tx_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= addr;
        @(posedge clk);
        cfg_we   <= 1'b0;
        dev_addr = addr;
    endtask

    // Mostly well-formed packets, some abandoned ones and loose words
    task automatic random_words(input int target);
        int sent;
        int kind;
        int n;
        logic [7:0] len;
        sent = 0;
        while (sent < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 88)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
                len = ($urandom_range(0, 3) == 0) ? 8'(n + 2) : 8'($urandom_range(3, 255));
                for (int i = 0; i < n; i++)
                begin
                    // abandoned packets never see their last word
                    if (i == 0)
                        send_word(plan_row(8'($urandom_range(0, 255)), len,
                                           8'($urandom_range(0, 255)), 1'b1,
                                           (n == 1) && (kind < 80), 4'd0, '0));
                    else
                        send_random(1'b0, (i == n - 1) && (kind < 80));
                end
                sent += n;
            end
            else
            begin
                send_random(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    initial
    begin
        // first+last at both extremes, typed in against the reset address
        directed_rows[0]  = plan_row(8'h00, 8'h03, 8'h00, 1'b1, 1'b1, 4'd12,
            {SYNC_HI, SYNC_LO, ADDR_RESET, 8'h00, LEN_HI, 8'h03, 8'h00, 16'h0003});
        directed_rows[1]  = plan_row(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 4'd12,
            {SYNC_HI, SYNC_LO, ADDR_RESET, 8'hFF, LEN_HI, 8'hFF, 8'hFF, 16'h02FD});
        // ordinary three-word packet
        directed_rows[2]  = plan_row(8'h01, 8'h05, 8'h55, 1'b1, 1'b0, 4'd0, '0);
        directed_rows[3]  = plan_row(8'h00, 8'h00, 8'hAA, 1'b0, 1'b0, 4'd0, '0);
        directed_rows[4]  = plan_row(8'h00, 8'h00, 8'h3C, 1'b0, 1'b1, 4'd0, '0);
        // new first while a packet is open
        directed_rows[5]  = plan_row(8'h07, 8'h0A, 8'h11, 1'b1, 1'b0, 4'd0, '0);
        directed_rows[6]  = plan_row(8'h00, 8'h00, 8'h99, 1'b0, 1'b0, 4'd0, '0);
        directed_rows[7]  = plan_row(8'h09, 8'h04, 8'h22, 1'b1, 1'b0, 4'd0, '0);
        directed_rows[8]  = plan_row(8'h00, 8'h00, 8'h33, 1'b0, 1'b1, 4'd0, '0);
        // loose word while idle, then closing it without a header
        directed_rows[9]  = plan_row(8'h00, 8'h00, 8'h44, 1'b0, 1'b0, 4'd1,
            {8'h44, 88'h0});
        directed_rows[10] = plan_row(8'h00, 8'h00, 8'h80, 1'b0, 1'b1, 4'd3,
            {8'h80, 16'h00C4, 72'h0});
        directed_rows[11] = plan_row(8'h00, 8'h00, 8'hFE, 1'b0, 1'b1, 4'd3,
            {8'hFE, 16'h00FE, 72'h0});
        // length field disagrees with the content count, both ways
        directed_rows[12] = plan_row(8'h0C, 8'hFF, 8'h01, 1'b1, 1'b0, 4'd0, '0);
        directed_rows[13] = plan_row(8'h00, 8'h00, 8'h02, 1'b0, 1'b1, 4'd0, '0);
        directed_rows[14] = plan_row(8'h5A, 8'h03, 8'hA5, 1'b1, 1'b0, 4'd0, '0);
        directed_rows[15] = plan_row(8'h00, 8'h00, 8'h5A, 1'b0, 1'b0, 4'd0, '0);
        directed_rows[16] = plan_row(8'h00, 8'h00, 8'hC3, 1'b0, 1'b0, 4'd0, '0);
        directed_rows[17] = plan_row(8'h00, 8'h00, 8'h3C, 1'b0, 1'b0, 4'd0, '0);
        directed_rows[18] = plan_row(8'h00, 8'h00, 8'hFF, 1'b0, 1'b1, 4'd0, '0);
        directed_rows[19] = plan_row(8'hA5, 8'h80, 8'h7F, 1'b1, 1'b1, 4'd0, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_word(directed_rows[i]);

        write_address(32'h0000_0000);
        random_words(45);

        // no idling on either side for this stretch
        write_address($urandom());
        quiet = 1'b1;
        random_words(45);
        quiet = 1'b0;

        write_address(32'hFFFF_FFFF);
        random_words(40);

        cmd_valid <= 1'b0;
        @(posedge clk);
        while (tx_expected.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
